FILE: hdl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared widths, types and constants for the frustum point cull pipeline.
// ----------------------------------------------------------------------------
package fpc_pkg;

  // Coordinate width, signed Q16.8 by default (legal range 16..32)
  localparam int COORD_W    = 24;

  // Configuration register file
  localparam int NUM_REGS   = 8;
  localparam int REG_W      = 32;
  localparam int REG_SEL_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = REG_SEL_W + 1;

  // Matrix element (Q8.8) and plane coefficient (Q9.8)
  localparam int ELEM_W     = 16;
  localparam int COEF_W     = ELEM_W + 1;
  localparam int FRAC_SHIFT = 8;

  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int NUM_COLS   = NUM_AXES + 1;

  // Exact product and four-term sum widths
  localparam int PROD_W     = COEF_W + COORD_W;
  localparam int SUM_W      = PROD_W + 2;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic        [REG_W-1:0]    cfg_reg_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic signed [ELEM_W-1:0]   elem_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [NUM_PLANES-1:0] pass_t;

  // Pipeline advance enables, one per register stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

FILE: hdl/fpc_cfg.sv
// ----------------------------------------------------------------------------
// fpc_cfg
// Matrix register file and registered plane coefficients.
// ----------------------------------------------------------------------------
module fpc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  fpc_pkg::cfg_idx_t   cfg_index_i,
  input  fpc_pkg::cfg_reg_t   cfg_data_i,
  output fpc_pkg::coef_t      coef_o [fpc_pkg::NUM_PLANES][fpc_pkg::NUM_COLS]
);

  fpc_pkg::cfg_reg_t cfg_q  [fpc_pkg::NUM_REGS];
  fpc_pkg::coef_t    coef_d [fpc_pkg::NUM_PLANES][fpc_pkg::NUM_COLS];
  fpc_pkg::coef_t    coef_q [fpc_pkg::NUM_PLANES][fpc_pkg::NUM_COLS];
  logic              wr_en;

  // indexes past the register file are dropped
  assign wr_en = cfg_valid_i &&
                 (cfg_index_i < fpc_pkg::cfg_idx_t'(fpc_pkg::NUM_REGS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < fpc_pkg::NUM_REGS; r++) begin
        cfg_q[r] <= '0;
      end
    end else if (wr_en) begin
      cfg_q[cfg_index_i[fpc_pkg::REG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  // plane p: row 3 plus (even p) or minus (odd p) row p/2
  for (genvar p = 0; p < fpc_pkg::NUM_PLANES; p++) begin : g_plane
    localparam int  ROW   = p / 2;
    localparam int  SEL   = ROW / 2;
    localparam int  HOFS  = (ROW % 2) * fpc_pkg::ELEM_W;
    localparam bit  MINUS = (p % 2) == 1;
    for (genvar c = 0; c < fpc_pkg::NUM_COLS; c++) begin : g_col
      fpc_pkg::elem_t e3;
      fpc_pkg::elem_t er;
      assign e3 = cfg_q[c*2 + 1][fpc_pkg::REG_W-1 -: fpc_pkg::ELEM_W];
      assign er = cfg_q[c*2 + SEL][HOFS +: fpc_pkg::ELEM_W];
      assign coef_d[p][c] = MINUS ? fpc_pkg::coef_t'(e3) - fpc_pkg::coef_t'(er)
                                  : fpc_pkg::coef_t'(e3) + fpc_pkg::coef_t'(er);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < fpc_pkg::NUM_PLANES; p++) begin
        for (int c = 0; c < fpc_pkg::NUM_COLS; c++) begin
          coef_q[p][c] <= '0;
        end
      end
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

FILE: hdl/fpc_mul.sv
// ----------------------------------------------------------------------------
// fpc_mul
// Product stage: coefficient times coordinate for every plane and axis.
// ----------------------------------------------------------------------------
module fpc_mul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fpc_pkg::coord_t coord_i [fpc_pkg::NUM_AXES],
  input  fpc_pkg::coef_t  coef_i  [fpc_pkg::NUM_PLANES][fpc_pkg::NUM_COLS],
  output logic            valid_o,
  output fpc_pkg::prod_t  prod_o  [fpc_pkg::NUM_PLANES][fpc_pkg::NUM_AXES],
  output fpc_pkg::coef_t  dcoef_o [fpc_pkg::NUM_PLANES]
);

  logic           valid_q;
  fpc_pkg::prod_t prod_q  [fpc_pkg::NUM_PLANES][fpc_pkg::NUM_AXES];
  fpc_pkg::coef_t dcoef_q [fpc_pkg::NUM_PLANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p < fpc_pkg::NUM_PLANES; p++) begin
        for (int a = 0; a < fpc_pkg::NUM_AXES; a++) begin
          prod_q[p][a] <= fpc_pkg::prod_t'(coef_i[p][a]) *
                          fpc_pkg::prod_t'(coord_i[a]);
        end
        dcoef_q[p] <= coef_i[p][fpc_pkg::NUM_COLS-1];
      end
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign dcoef_o = dcoef_q;

endmodule

FILE: hdl/fpc_add.sv
// ----------------------------------------------------------------------------
// fpc_add
// First add stage: two partial sums per plane (x+y terms, z+offset terms).
// ----------------------------------------------------------------------------
module fpc_add (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  fpc_pkg::prod_t prod_i  [fpc_pkg::NUM_PLANES][fpc_pkg::NUM_AXES],
  input  fpc_pkg::coef_t dcoef_i [fpc_pkg::NUM_PLANES],
  output logic           valid_o,
  output fpc_pkg::sum_t  psum_a_o [fpc_pkg::NUM_PLANES],
  output fpc_pkg::sum_t  psum_b_o [fpc_pkg::NUM_PLANES]
);

  logic          valid_q;
  fpc_pkg::sum_t psum_a_q [fpc_pkg::NUM_PLANES];
  fpc_pkg::sum_t psum_b_q [fpc_pkg::NUM_PLANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // D is Q9.8, products carry 16 fraction bits: align D by 8
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p < fpc_pkg::NUM_PLANES; p++) begin
        psum_a_q[p] <= fpc_pkg::sum_t'(prod_i[p][0]) + fpc_pkg::sum_t'(prod_i[p][1]);
        psum_b_q[p] <= fpc_pkg::sum_t'(prod_i[p][2]) +
                       (fpc_pkg::sum_t'(dcoef_i[p]) <<< fpc_pkg::FRAC_SHIFT);
      end
    end
  end

  assign valid_o  = valid_q;
  assign psum_a_o = psum_a_q;
  assign psum_b_o = psum_b_q;

endmodule

FILE: hdl/fpc_cmp.sv
// ----------------------------------------------------------------------------
// fpc_cmp
// Final add and sign test per plane; holds the output register.
// ----------------------------------------------------------------------------
module fpc_cmp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  fpc_pkg::sum_t  psum_a_i [fpc_pkg::NUM_PLANES],
  input  fpc_pkg::sum_t  psum_b_i [fpc_pkg::NUM_PLANES],
  output logic           valid_o,
  output logic           inside_o,
  output fpc_pkg::pass_t pass_o
);

  logic           valid_q;
  logic           inside_q;
  fpc_pkg::pass_t pass_d;
  fpc_pkg::pass_t pass_q;
  fpc_pkg::sum_t  plane_dist [fpc_pkg::NUM_PLANES];

  // strictly positive: sign clear and nonzero
  always_comb begin
    for (int p = 0; p < fpc_pkg::NUM_PLANES; p++) begin
      plane_dist[p] = psum_a_i[p] + psum_b_i[p];
      pass_d[p]     = !plane_dist[p][fpc_pkg::SUM_W-1] && (plane_dist[p] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pass_q   <= pass_d;
      inside_q <= &pass_d;
    end
  end

  assign valid_o  = valid_q;
  assign inside_o = inside_q;
  assign pass_o   = pass_q;

endmodule

FILE: hdl/frustum_point_cull_unit.sv
// ----------------------------------------------------------------------------
// frustum_point_cull_unit
// Tests one point against the six view-frustum planes taken from a
// column-major view-projection matrix; reports per-plane pass and inside.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Transaction
//  --------+-----------+-------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o | point_x/y/z (signed Q16.8)
//  out     | source    | out_valid_o/out_stall_i | inside_res, plane_pass[5:0]
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Four register stages: input, multiply, partial add, final add + compare.
//  One point per cycle sustained while the output is not stalled.
//  The multiply stage (17 x COORD_W per plane and axis) sets the clock.
//  Reset clears valid bits and the matrix registers (all-zero matrix).
//  A stall on the output only backs up stages that hold a valid point;
//  bubbles ahead of it still fill, so in_stall_o rises only when full.
//  Coefficients are registered in the cycle after a cfg write.
//
module frustum_point_cull_unit (
  input  logic                clk_i,
  input  logic                rst_ni,

  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  fpc_pkg::cfg_idx_t   cfg_index_i,
  input  fpc_pkg::cfg_reg_t   cfg_data_i,

  // point input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fpc_pkg::coord_t     point_x_i,
  input  fpc_pkg::coord_t     point_y_i,
  input  fpc_pkg::coord_t     point_z_i,

  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                inside_res_o,
  output fpc_pkg::pass_t      plane_pass_o
);

  fpc_pkg::stage_en_t en;

  // stage 1: input register
  logic            s1_valid_q;
  fpc_pkg::coord_t s1_coord_q [fpc_pkg::NUM_AXES];

  // stage 2/3 interconnect
  logic            s2_valid;
  fpc_pkg::prod_t  s2_prod  [fpc_pkg::NUM_PLANES][fpc_pkg::NUM_AXES];
  fpc_pkg::coef_t  s2_dcoef [fpc_pkg::NUM_PLANES];
  logic            s3_valid;
  fpc_pkg::sum_t   s3_psum_a [fpc_pkg::NUM_PLANES];
  fpc_pkg::sum_t   s3_psum_b [fpc_pkg::NUM_PLANES];

  fpc_pkg::coef_t  coef [fpc_pkg::NUM_PLANES][fpc_pkg::NUM_COLS];

  // the register file takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  // a stage loads when empty or when the next one loads
  always_comb begin
    en.s4 = !out_valid_o || !out_stall_i;
    en.s3 = !s3_valid   || en.s4;
    en.s2 = !s2_valid   || en.s3;
    en.s1 = !s1_valid_q || en.s2;
  end

  assign in_stall_o = !en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en.s1) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      s1_coord_q[0] <= point_x_i;
      s1_coord_q[1] <= point_y_i;
      s1_coord_q[2] <= point_z_i;
    end
  end

  fpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  fpc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en.s2),
    .valid_i (s1_valid_q),
    .coord_i (s1_coord_q),
    .coef_i  (coef),
    .valid_o (s2_valid),
    .prod_o  (s2_prod),
    .dcoef_o (s2_dcoef)
  );

  fpc_add u_add (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en.s3),
    .valid_i  (s2_valid),
    .prod_i   (s2_prod),
    .dcoef_i  (s2_dcoef),
    .valid_o  (s3_valid),
    .psum_a_o (s3_psum_a),
    .psum_b_o (s3_psum_b)
  );

  fpc_cmp u_cmp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en.s4),
    .valid_i  (s3_valid),
    .psum_a_i (s3_psum_a),
    .psum_b_i (s3_psum_b),
    .valid_o  (out_valid_o),
    .inside_o (inside_res_o),
    .pass_o   (plane_pass_o)
  );

  // stall only comes from a held result at the output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stall without a held output");

  // an empty pipeline never stalls the input
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_valid_q && !s2_valid && !s3_valid && !out_valid_o) |-> !in_stall_o)
    else $error("empty pipeline stalls input");

  // an accepted point lands in stage 1
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted point lost at stage 1");

  // a full pipeline behind a stalled output must stall the input
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && s3_valid && s2_valid && s1_valid_q) |-> in_stall_o)
    else $error("full pipeline accepted a point");

endmodule
